>>> sv/cbpe_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the cubic Bezier point evaluator.
package cbpe_pkg;

    // Control point table
    localparam int MAX_POINTS = 64;
    localparam int BANKS      = 4;
    localparam int BANK_DEPTH = MAX_POINTS / BANKS;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam int PT_W       = 32;
    localparam int BANK_W     = 3 * PT_W;
    localparam int SPAN       = 3;

    // Field widths
    localparam int IDX_W      = 6;
    localparam int K_W        = 6;
    localparam int U_W        = 16;
    localparam int PARAM_W    = K_W + U_W;
    localparam int CNT_W      = 7;
    localparam int LIM_W      = CNT_W + 1;
    localparam int STATUS_W   = 2;

    // Stream payload layout
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 96;
    localparam int S_IDX_LSB  = 0;
    localparam int S_X_LSB    = S_IDX_LSB + IDX_W;
    localparam int S_Y_LSB    = S_X_LSB + PT_W;
    localparam int S_Z_LSB    = S_Y_LSB + PT_W;
    localparam int S_PRM_LSB  = S_Z_LSB + PT_W;

    // Blend arithmetic widths
    localparam int V_W        = U_W + 1;
    localparam int VV_W       = 2 * U_W + 1;
    localparam int UU_W       = 2 * U_W;
    localparam int W_W        = 49;
    localparam int WLO_W      = 24;
    localparam int WHI_W      = W_W - WLO_W;
    localparam int PH_W       = PT_W + WHI_W + 1;
    localparam int PL_W       = PT_W + WLO_W + 1;
    localparam int SH_W       = PH_W + 2;
    localparam int SL_W       = PL_W + 2;
    localparam int TOT_W      = SH_W + WLO_W;
    localparam int FRAC_W     = 48;
    localparam int Q_W        = TOT_W - FRAC_W;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef logic [3:0][PT_W-1:0] quad_t;
    typedef logic [3:0][W_W-1:0]  wquad_t;

    // Per-item tag that rides next to the datapath
    typedef struct packed {
        logic    use_q;
        status_t status;
    } tag_t;

    // Stage advance enables for the blend pipeline
    typedef struct packed {
        logic c;
        logic d;
        logic e;
    } stage_en_t;

endpackage

>>> sv/cubic_bezier_point_evaluator.sv
`timescale 1ns / 1ps
// Top level: piecewise cubic Bezier point evaluator with a banked point table.
// An item passes through stages A to E and then the output register to m_axis.
// One item per cycle unless stalled; the four table banks each serve one point per cycle.
// A stalled output holds only the stages behind a full stage; bubbles still move up.
// Reset (aresetn low, synchronous) clears all valid bits and point_count.
// The point table is not cleared; entries read before being loaded are undefined.
module cubic_bezier_point_evaluator (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Configuration: point_count
    input  logic                               cfg_wr_en,
    input  logic [cbpe_pkg::CNT_W-1:0]         cfg_wr_data,

    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] point_z,
    // [123:102] curve_param, [127:124] zero
    input  logic [cbpe_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] op
    input  logic                               s_axis_tuser,

    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    output logic [cbpe_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [cbpe_pkg::STATUS_W-1:0]      m_axis_tuser
);

    localparam logic [cbpe_pkg::V_W-1:0] ONE_U = cbpe_pkg::V_W'(1) << cbpe_pkg::U_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [cbpe_pkg::CNT_W-1:0] point_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= '0;
        end else if (cfg_wr_en) begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage advance chain: a stage takes new data when empty or when the
    // stage after it moves on.
    // ------------------------------------------------------------------
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg, vld_e_reg;
    logic m_valid_reg;
    logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_out;
    logic s_xfer;
    cbpe_pkg::stage_en_t coord_en;

    assign adv_out = !m_valid_reg || m_axis_tready;
    assign adv_e   = !vld_e_reg || adv_out;
    assign adv_d   = !vld_d_reg || adv_e;
    assign adv_c   = !vld_c_reg || adv_d;
    assign adv_b   = !vld_b_reg || adv_c;
    assign adv_a   = !vld_a_reg || adv_b;

    assign s_axis_tready = adv_a;
    assign s_xfer        = s_axis_tvalid && adv_a;

    assign coord_en.c = adv_c;
    assign coord_en.d = adv_d;
    assign coord_en.e = adv_e;

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    cbpe_pkg::op_t               s_op;
    logic [cbpe_pkg::IDX_W-1:0]  s_idx;
    logic [cbpe_pkg::PT_W-1:0]   s_x, s_y, s_z;
    logic [cbpe_pkg::PARAM_W-1:0] s_param;
    logic [cbpe_pkg::K_W-1:0]    s_k;
    logic [cbpe_pkg::U_W-1:0]    s_u;

    assign s_op    = cbpe_pkg::op_t'(s_axis_tuser);
    assign s_idx   = s_axis_tdata[cbpe_pkg::S_IDX_LSB +: cbpe_pkg::IDX_W];
    assign s_x     = s_axis_tdata[cbpe_pkg::S_X_LSB +: cbpe_pkg::PT_W];
    assign s_y     = s_axis_tdata[cbpe_pkg::S_Y_LSB +: cbpe_pkg::PT_W];
    assign s_z     = s_axis_tdata[cbpe_pkg::S_Z_LSB +: cbpe_pkg::PT_W];
    assign s_param = s_axis_tdata[cbpe_pkg::S_PRM_LSB +: cbpe_pkg::PARAM_W];
    assign s_k     = s_param[cbpe_pkg::PARAM_W-1:cbpe_pkg::U_W];
    assign s_u     = s_param[cbpe_pkg::U_W-1:0];

    // ------------------------------------------------------------------
    // Stage A: table read, range check, squares of u and 1-u
    // ------------------------------------------------------------------
    logic [cbpe_pkg::LIM_W-1:0]  last_idx;
    logic [cbpe_pkg::LIM_W-1:0]  limit;
    logic                        range_err;
    logic                        slot_ok;
    logic [cbpe_pkg::V_W-1:0]    v_next;
    cbpe_pkg::tag_t              tag_a_next;
    logic [cbpe_pkg::VV_W-1:0]   vv_next;
    logic [cbpe_pkg::UU_W-1:0]   uu_next;

    cbpe_pkg::tag_t              tag_a_reg;
    logic [1:0]                  k_lo_a_reg;
    logic [cbpe_pkg::VV_W-1:0]   vv_a_reg;
    logic [cbpe_pkg::UU_W-1:0]   uu_a_reg;
    logic [cbpe_pkg::U_W-1:0]    u_a_reg;
    logic [cbpe_pkg::V_W-1:0]    v_a_reg;

    always_comb begin
        last_idx  = cbpe_pkg::LIM_W'(s_k) + cbpe_pkg::LIM_W'(cbpe_pkg::SPAN);
        limit     = (32'(point_count_reg) < cbpe_pkg::MAX_POINTS)
                  ? cbpe_pkg::LIM_W'(point_count_reg)
                  : cbpe_pkg::LIM_W'(cbpe_pkg::MAX_POINTS);
        range_err = (last_idx >= limit);
        slot_ok   = (32'(s_idx) < cbpe_pkg::MAX_POINTS);

        v_next  = ONE_U - cbpe_pkg::V_W'(s_u);
        vv_next = cbpe_pkg::VV_W'(34'(v_next) * 34'(v_next));
        uu_next = cbpe_pkg::UU_W'(s_u) * cbpe_pkg::UU_W'(s_u);

        tag_a_next.use_q  = (s_op == cbpe_pkg::OP_EVAL) && !range_err;
        tag_a_next.status = ((s_op == cbpe_pkg::OP_EVAL) && range_err)
                          ? cbpe_pkg::ST_RANGE : cbpe_pkg::ST_OK;
    end

    // Four banks by index modulo 4: points k..k+3 hit each bank once.
    logic [cbpe_pkg::BANK_W-1:0] ram_rd [cbpe_pkg::BANKS];

    for (genvar b = 0; b < cbpe_pkg::BANKS; b++) begin : g_bank
        logic [1:0]                 rd_off;
        logic [cbpe_pkg::K_W:0]     rd_pos;
        logic [cbpe_pkg::ROW_W-1:0] rd_row;
        logic                       wr_hit;

        assign rd_off = 2'(b) - s_k[1:0];
        assign rd_pos = {1'b0, s_k} + (cbpe_pkg::K_W + 1)'(rd_off);
        assign rd_row = cbpe_pkg::ROW_W'(rd_pos >> 2);
        assign wr_hit = s_xfer && (s_op == cbpe_pkg::OP_LOAD) && slot_ok
                     && (s_idx[1:0] == 2'(b));

        cbpe_ram #(
            .WIDTH (cbpe_pkg::BANK_W),
            .DEPTH (cbpe_pkg::BANK_DEPTH)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (wr_hit),
            .wr_addr (cbpe_pkg::ROW_W'(s_idx >> 2)),
            .wr_data ({s_z, s_y, s_x}),
            .rd_en   (adv_a),
            .rd_addr (rd_row),
            .rd_data (ram_rd[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (adv_a) begin
            vld_a_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            tag_a_reg  <= tag_a_next;
            k_lo_a_reg <= s_k[1:0];
            vv_a_reg   <= vv_next;
            uu_a_reg   <= uu_next;
            u_a_reg    <= s_u;
            v_a_reg    <= v_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: Bernstein weights, points put back in curve order
    // ------------------------------------------------------------------
    logic [cbpe_pkg::VV_W+cbpe_pkg::U_W+1:0] t1;
    logic [cbpe_pkg::UU_W+cbpe_pkg::V_W+1:0] t2;
    cbpe_pkg::wquad_t w_next;
    cbpe_pkg::quad_t  px_next, py_next, pz_next;
    logic [1:0]       bank_sel;

    cbpe_pkg::tag_t   tag_b_reg;
    cbpe_pkg::wquad_t w_b_reg;
    cbpe_pkg::quad_t  px_b_reg, py_b_reg, pz_b_reg;

    always_comb begin
        // (1-u)^3, 3(1-u)^2 u, 3(1-u) u^2, u^3 in Q.48; times three as x + 2x
        t1 = (cbpe_pkg::VV_W + cbpe_pkg::U_W + 2)'(vv_a_reg)
           * (cbpe_pkg::VV_W + cbpe_pkg::U_W + 2)'(u_a_reg);
        t2 = (cbpe_pkg::UU_W + cbpe_pkg::V_W + 2)'(uu_a_reg)
           * (cbpe_pkg::UU_W + cbpe_pkg::V_W + 2)'(v_a_reg);
        w_next[0] = cbpe_pkg::W_W'(50'(vv_a_reg) * 50'(v_a_reg));
        w_next[1] = cbpe_pkg::W_W'(t1 + (t1 << 1));
        w_next[2] = cbpe_pkg::W_W'(t2 + (t2 << 1));
        w_next[3] = cbpe_pkg::W_W'(cbpe_pkg::UU_W'(uu_a_reg) * 48'(u_a_reg));

        bank_sel = '0;
        for (int i = 0; i < 4; i++) begin
            bank_sel   = k_lo_a_reg + 2'(i);
            px_next[i] = ram_rd[bank_sel][0 * cbpe_pkg::PT_W +: cbpe_pkg::PT_W];
            py_next[i] = ram_rd[bank_sel][1 * cbpe_pkg::PT_W +: cbpe_pkg::PT_W];
            pz_next[i] = ram_rd[bank_sel][2 * cbpe_pkg::PT_W +: cbpe_pkg::PT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_b_reg <= 1'b0;
        end else if (adv_b) begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_b) begin
            tag_b_reg <= tag_a_reg;
            w_b_reg   <= w_next;
            px_b_reg  <= px_next;
            py_b_reg  <= py_next;
            pz_b_reg  <= pz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages C, D, E: products, sums, rounding per coordinate
    // ------------------------------------------------------------------
    logic [cbpe_pkg::Q_W-1:0] qx, qy, qz;
    cbpe_pkg::tag_t tag_c_reg, tag_d_reg, tag_e_reg;

    cbpe_coord u_coord_x (
        .aclk (aclk),
        .en   (coord_en),
        .pt   (px_b_reg),
        .wt   (w_b_reg),
        .q    (qx)
    );

    cbpe_coord u_coord_y (
        .aclk (aclk),
        .en   (coord_en),
        .pt   (py_b_reg),
        .wt   (w_b_reg),
        .q    (qy)
    );

    cbpe_coord u_coord_z (
        .aclk (aclk),
        .en   (coord_en),
        .pt   (pz_b_reg),
        .wt   (w_b_reg),
        .q    (qz)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end else begin
            if (adv_c) begin
                vld_c_reg <= vld_b_reg;
            end
            if (adv_d) begin
                vld_d_reg <= vld_c_reg;
            end
            if (adv_e) begin
                vld_e_reg <= vld_d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_c) begin
            tag_c_reg <= tag_b_reg;
        end
        if (adv_d) begin
            tag_d_reg <= tag_c_reg;
        end
        if (adv_e) begin
            tag_e_reg <= tag_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate to Q16.16, zero loads and range errors
    // ------------------------------------------------------------------
    logic [cbpe_pkg::Q_W-1:0]  q_all [3];
    logic [cbpe_pkg::PT_W-1:0] pos_sat [3];
    logic [2:0]                sat_any;
    logic [cbpe_pkg::M_TDATA_W-1:0] m_tdata_next;
    cbpe_pkg::status_t         m_status_next;

    logic [cbpe_pkg::M_TDATA_W-1:0] m_tdata_reg;
    cbpe_pkg::status_t              m_status_reg;

    assign q_all[0] = qx;
    assign q_all[1] = qy;
    assign q_all[2] = qz;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sat_any[c] = 1'b0;
            pos_sat[c] = q_all[c][cbpe_pkg::PT_W-1:0];
            if (!q_all[c][cbpe_pkg::Q_W-1] &&
                (q_all[c][cbpe_pkg::Q_W-2:cbpe_pkg::PT_W-1] != '0)) begin
                sat_any[c] = 1'b1;
                pos_sat[c] = {1'b0, {(cbpe_pkg::PT_W - 1){1'b1}}};
            end else if (q_all[c][cbpe_pkg::Q_W-1] &&
                         (q_all[c][cbpe_pkg::Q_W-2:cbpe_pkg::PT_W-1] != '1)) begin
                sat_any[c] = 1'b1;
                pos_sat[c] = {1'b1, {(cbpe_pkg::PT_W - 1){1'b0}}};
            end
        end

        if (tag_e_reg.use_q) begin
            m_tdata_next  = {pos_sat[2], pos_sat[1], pos_sat[0]};
            m_status_next = (sat_any != '0) ? cbpe_pkg::ST_SAT : cbpe_pkg::ST_OK;
        end else begin
            m_tdata_next  = '0;
            m_status_next = tag_e_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= vld_e_reg;
        end
    end

    // Hold the payload while a result waits for the sink
    always_ff @(posedge aclk) begin
        if (adv_out) begin
            m_tdata_reg  <= m_tdata_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

>>> sv/cbpe_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cbpe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/cbpe_coord.sv
`timescale 1ns / 1ps
// Three-stage weighted sum and rounding for one coordinate.
module cbpe_coord (
    input  logic                          aclk,
    input  cbpe_pkg::stage_en_t           en,
    input  cbpe_pkg::quad_t               pt,
    input  cbpe_pkg::wquad_t              wt,
    output logic [cbpe_pkg::Q_W-1:0]      q
);

    localparam logic [cbpe_pkg::TOT_W-1:0] RND_HALF =
        cbpe_pkg::TOT_W'(1) << (cbpe_pkg::FRAC_W - 1);

    logic signed [cbpe_pkg::PH_W-1:0] prod_hi_next [4];
    logic signed [cbpe_pkg::PL_W-1:0] prod_lo_next [4];
    logic signed [cbpe_pkg::PH_W-1:0] prod_hi_reg  [4];
    logic signed [cbpe_pkg::PL_W-1:0] prod_lo_reg  [4];
    logic [cbpe_pkg::SH_W-1:0]        sum_hi_next;
    logic [cbpe_pkg::SL_W-1:0]        sum_lo_next;
    logic [cbpe_pkg::SH_W-1:0]        sum_hi_reg;
    logic [cbpe_pkg::SL_W-1:0]        sum_lo_reg;
    logic [cbpe_pkg::TOT_W-1:0]       total_next;
    logic [cbpe_pkg::Q_W-1:0]         q_reg;

    // Split each weight into high and low parts to keep multipliers narrow
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod_hi_next[i] = cbpe_pkg::PH_W'($signed(pt[i])) *
                cbpe_pkg::PH_W'($signed({1'b0, wt[i][cbpe_pkg::W_W-1:cbpe_pkg::WLO_W]}));
            prod_lo_next[i] = cbpe_pkg::PL_W'($signed(pt[i])) *
                cbpe_pkg::PL_W'($signed({1'b0, wt[i][cbpe_pkg::WLO_W-1:0]}));
        end
    end

    always_comb begin
        sum_hi_next = '0;
        sum_lo_next = '0;
        for (int i = 0; i < 4; i++) begin
            sum_hi_next = sum_hi_next +
                {{2{prod_hi_reg[i][cbpe_pkg::PH_W-1]}}, prod_hi_reg[i]};
            sum_lo_next = sum_lo_next +
                {{2{prod_lo_reg[i][cbpe_pkg::PL_W-1]}}, prod_lo_reg[i]};
        end
    end

    // Recombine, add half an LSB, keep the integer part (floor)
    always_comb begin
        total_next = {sum_hi_reg, {cbpe_pkg::WLO_W{1'b0}}}
                   + {{(cbpe_pkg::TOT_W - cbpe_pkg::SL_W){sum_lo_reg[cbpe_pkg::SL_W-1]}},
                      sum_lo_reg}
                   + RND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (en.c) begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
        end
        if (en.d) begin
            sum_hi_reg <= sum_hi_next;
            sum_lo_reg <= sum_lo_next;
        end
        if (en.e) begin
            q_reg <= total_next[cbpe_pkg::TOT_W-1:cbpe_pkg::FRAC_W];
        end
    end

    assign q = q_reg;

endmodule
